[hw/rtl/kmpsfr_pkg.sv]
// ----------------------------------------------------------------------------
// kmpsfr_pkg: shared types and constants for the streaming find-and-replace
// Sequencer states, register indexes, widths and byte lane selection.
// ----------------------------------------------------------------------------
`default_nettype none

package kmpsfr_pkg;

    // field and register widths
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    // bytes held by a low/high register pair
    localparam int STR_BYTES = 16;

    // parameter defaults
    localparam int PATTERN_MAX_DEF     = 16;
    localparam int REPLACEMENT_MAX_DEF = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REP_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REP_HI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REP_LEN = 3'd5;

    // sequencer states
    typedef enum logic [2:0] {
        S_BUILD,
        S_IDLE,
        S_SCAN,
        S_FALL,
        S_REPL,
        S_EOT,
        S_LAST
    } t_state;

    // pick one byte out of a 16-byte string held as two 64-bit words
    function automatic logic [BYTE_W-1:0] byte_of(
        input logic [CFG_W-1:0] lo,
        input logic [CFG_W-1:0] hi,
        input logic [3:0]       idx
    );
        logic [CFG_W-1:0] word;
        logic [CFG_W-1:0] shifted;
        word    = idx[3] ? hi : lo;
        shifted = word >> {idx[2:0], 3'b000};
        return shifted[BYTE_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/kmp_stream_find_replace.sv]
// The sequencer shares one comparator and one failure-table read port and works through one
// accepted byte at a time; the input stalls until it is back in idle. Each emitted byte, each
// failure link followed, a completed match and any output stall lengthen the work on a byte.
// With matching disabled the byte is passed straight through. After reset and any pattern
// register write the table is rebuilt, input stalled.
// Reset: synchronous, active low, clears control.
// ----------------------------------------------------------------------------
// kmp_stream_find_replace: streaming find-and-replace with a KMP matcher
// Bytes in, rewritten bytes out; matches of the pattern become the replacement.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_stream_find_replace #(
    parameter int PATTERN_MAX     = kmpsfr_pkg::PATTERN_MAX_DEF,
    parameter int REPLACEMENT_MAX = kmpsfr_pkg::REPLACEMENT_MAX_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // configuration write port
    input  wire                                   i_cfg_we,
    input  wire  [kmpsfr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [kmpsfr_pkg::CFG_W-1:0]          i_cfg_data,
    // text input channel
    input  wire                                   i_valid,
    output logic                                  o_stall,
    input  wire  [kmpsfr_pkg::BYTE_W-1:0]         i_text_byte,
    input  wire                                   i_end_of_text,
    // rewritten text output channel
    output logic                                  o_valid,
    input  wire                                   i_stall,
    output logic [kmpsfr_pkg::BYTE_W-1:0]         o_out_byte,
    output logic                                  o_run_last,
    output logic                                  o_text_last
);

    localparam int BW      = kmpsfr_pkg::BYTE_W;
    localparam int PW      = kmpsfr_pkg::POS_W;
    localparam int CW      = kmpsfr_pkg::CFG_W;
    localparam int PAT_CAP = (PATTERN_MAX < kmpsfr_pkg::STR_BYTES) ?
                             PATTERN_MAX : kmpsfr_pkg::STR_BYTES;
    localparam int REP_CAP = (REPLACEMENT_MAX < kmpsfr_pkg::STR_BYTES) ?
                             REPLACEMENT_MAX : kmpsfr_pkg::STR_BYTES;
    localparam int IW      = $clog2(PAT_CAP);

    // configuration registers
    logic [CW-1:0] r_pat_lo, r_pat_hi, r_rep_lo, r_rep_hi;
    logic [PW-1:0] r_pat_len, r_rep_len;
    logic          pat_wr;

    // failure table
    logic [PW-1:0] r_fail [PAT_CAP];
    logic          tbl_we;
    logic [IW-1:0] tbl_waddr;
    logic [PW-1:0] tbl_wdata;
    logic [PW-1:0] tbl_pos;
    logic [PW-1:0] tbl_pos_m1;
    logic [PW-1:0] fail_rd;

    // sequencer state
    kmpsfr_pkg::t_state r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_j, n_j;
    logic [PW-1:0] r_idx, n_idx;
    logic [PW-1:0] r_end, n_end;
    logic [PW-1:0] r_nj, n_nj;
    logic [PW-1:0] r_bi, n_bi;
    logic [PW-1:0] r_bk, n_bk;
    logic [BW-1:0] r_c, n_c;
    logic          r_eot, n_eot;

    // one-deep hold stage and output register
    logic          r_hold_vld, n_hold_vld;
    logic [BW-1:0] r_hold_byte, n_hold_byte;
    logic          r_out_vld, n_out_vld;
    logic [BW-1:0] r_out_byte, n_out_byte;
    logic          r_out_run_last, n_out_run_last;
    logic          r_out_text_last, n_out_text_last;

    // shared compare unit and helpers
    logic [PW-1:0] plen, rlen;
    logic [PW-1:0] cmp_pos;
    logic [BW-1:0] cmp_a, cmp_b;
    logic          cmp_eq;
    logic [PW-1:0] nj_safe;
    logic [PW-1:0] k_next;
    logic [PW-1:0] j_inc;
    logic          e_vld, e_go, fin, push, out_free, can_emit;
    logic [BW-1:0] e_byte;

    // effective lengths, saturated at capacity
    assign plen = (r_pat_len > PW'(PAT_CAP)) ? PW'(PAT_CAP) : r_pat_len;
    assign rlen = (r_rep_len > PW'(REP_CAP)) ? PW'(REP_CAP) : r_rep_len;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= '0;
            r_rep_lo  <= '0;
            r_rep_hi  <= '0;
            r_rep_len <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kmpsfr_pkg::REG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                kmpsfr_pkg::REG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                kmpsfr_pkg::REG_PAT_LEN: r_pat_len <= i_cfg_data[PW-1:0];
                kmpsfr_pkg::REG_REP_LO:  r_rep_lo  <= i_cfg_data;
                kmpsfr_pkg::REG_REP_HI:  r_rep_hi  <= i_cfg_data;
                kmpsfr_pkg::REG_REP_LEN: r_rep_len <= i_cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    assign pat_wr = i_cfg_we && ((i_cfg_index == kmpsfr_pkg::REG_PAT_LO)  ||
                                 (i_cfg_index == kmpsfr_pkg::REG_PAT_HI)  ||
                                 (i_cfg_index == kmpsfr_pkg::REG_PAT_LEN));

    // failure table write port
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_fail[tbl_waddr] <= tbl_wdata;
        end
    end

    // single table read port: entry at position minus one
    assign tbl_pos    = (r_state == kmpsfr_pkg::S_BUILD) ? r_bk : r_j;
    assign tbl_pos_m1 = tbl_pos - PW'(1);
    assign fail_rd    = r_fail[tbl_pos_m1[IW-1:0]];

    // shared byte comparator: pattern byte against pattern byte or text byte
    assign cmp_pos = (r_state == kmpsfr_pkg::S_BUILD) ? r_bi : r_j;
    assign cmp_a   = kmpsfr_pkg::byte_of(r_pat_lo, r_pat_hi, cmp_pos[3:0]);
    assign cmp_b   = (r_state == kmpsfr_pkg::S_BUILD) ?
                     kmpsfr_pkg::byte_of(r_pat_lo, r_pat_hi, r_bk[3:0]) : r_c;
    assign cmp_eq  = (cmp_a == cmp_b);

    assign nj_safe = (fail_rd >= r_j) ? '0 : fail_rd;
    assign k_next  = r_bk + {{(PW-1){1'b0}}, cmp_eq};
    assign j_inc   = r_j + PW'(1);

    // output side flow
    assign out_free = !r_out_vld || !i_stall;
    assign can_emit = !r_hold_vld || out_free;

    // sequencer next state, emission and table writes
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_j       = r_j;
        n_idx     = r_idx;
        n_end     = r_end;
        n_nj      = r_nj;
        n_bi      = r_bi;
        n_bk      = r_bk;
        n_c       = r_c;
        n_eot     = r_eot;
        tbl_we    = 1'b0;
        tbl_waddr = r_bi[IW-1:0];
        tbl_wdata = k_next;
        e_vld     = 1'b0;
        e_byte    = r_c;
        fin       = 1'b0;

        unique case (r_state)
            kmpsfr_pkg::S_BUILD: begin
                if (r_bi == '0) begin
                    tbl_we    = 1'b1;
                    tbl_wdata = '0;
                    n_bi      = PW'(1);
                end else if (r_bi >= plen) begin
                    n_state = kmpsfr_pkg::S_IDLE;
                end else if ((r_bk != '0) && !cmp_eq) begin
                    n_bk = fail_rd;
                end else begin
                    tbl_we = 1'b1;
                    n_bk   = k_next;
                    n_bi   = r_bi + PW'(1);
                end
            end
            kmpsfr_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_c   = i_text_byte;
                    n_eot = i_end_of_text;
                    if (plen == '0) begin
                        // matching disabled: pass the byte through
                        e_vld   = 1'b1;
                        e_byte  = i_text_byte;
                        n_j     = '0;
                        n_state = kmpsfr_pkg::S_LAST;
                    end else begin
                        n_j     = (r_pos >= plen) ? '0 : r_pos;
                        n_state = kmpsfr_pkg::S_SCAN;
                    end
                end
            end
            kmpsfr_pkg::S_SCAN: begin
                if ((r_j != '0) && !cmp_eq) begin
                    // follow one failure link, release the dropped prefix
                    n_nj    = nj_safe;
                    n_end   = r_j - nj_safe;
                    n_idx   = '0;
                    n_state = kmpsfr_pkg::S_FALL;
                end else if (cmp_eq) begin
                    n_idx = '0;
                    if (j_inc >= plen) begin
                        n_j     = '0;
                        n_state = kmpsfr_pkg::S_REPL;
                    end else begin
                        n_j     = j_inc;
                        n_state = kmpsfr_pkg::S_EOT;
                    end
                end else begin
                    e_vld = 1'b1;
                    if (can_emit) begin
                        n_idx   = '0;
                        n_state = kmpsfr_pkg::S_EOT;
                    end
                end
            end
            kmpsfr_pkg::S_FALL: begin
                if (r_idx < r_end) begin
                    e_vld  = 1'b1;
                    e_byte = kmpsfr_pkg::byte_of(r_pat_lo, r_pat_hi, r_idx[3:0]);
                    if (can_emit) begin
                        n_idx = r_idx + PW'(1);
                    end
                end else begin
                    n_j     = r_nj;
                    n_state = kmpsfr_pkg::S_SCAN;
                end
            end
            kmpsfr_pkg::S_REPL: begin
                if (r_idx < rlen) begin
                    e_vld  = 1'b1;
                    e_byte = kmpsfr_pkg::byte_of(r_rep_lo, r_rep_hi, r_idx[3:0]);
                    if (can_emit) begin
                        n_idx = r_idx + PW'(1);
                    end
                end else begin
                    n_idx   = '0;
                    n_state = kmpsfr_pkg::S_EOT;
                end
            end
            kmpsfr_pkg::S_EOT: begin
                if (r_eot && (r_idx < r_j)) begin
                    // end of text: flush the pending partial match
                    e_vld  = 1'b1;
                    e_byte = kmpsfr_pkg::byte_of(r_pat_lo, r_pat_hi, r_idx[3:0]);
                    if (can_emit) begin
                        n_idx = r_idx + PW'(1);
                    end
                end else begin
                    if (r_eot) begin
                        n_j = '0;
                    end
                    n_state = kmpsfr_pkg::S_LAST;
                end
            end
            kmpsfr_pkg::S_LAST: begin
                if (!r_hold_vld) begin
                    n_pos   = r_j;
                    n_state = kmpsfr_pkg::S_IDLE;
                end else if (out_free) begin
                    fin     = 1'b1;
                    n_pos   = r_j;
                    n_state = kmpsfr_pkg::S_IDLE;
                end
            end
            default: n_state = kmpsfr_pkg::S_IDLE;
        endcase

        // a pattern change drops any partial match and rebuilds the table
        if (pat_wr) begin
            n_state = kmpsfr_pkg::S_BUILD;
            n_bi    = '0;
            n_bk    = '0;
            n_pos   = '0;
        end
    end

    // hold stage: the newest byte waits until its successor or the run end is known
    assign e_go = e_vld && can_emit;
    assign push = (e_go && r_hold_vld) || fin;

    always_comb begin
        n_hold_vld      = r_hold_vld;
        n_hold_byte     = r_hold_byte;
        n_out_vld       = r_out_vld;
        n_out_byte      = r_out_byte;
        n_out_run_last  = r_out_run_last;
        n_out_text_last = r_out_text_last;
        if (e_go) begin
            n_hold_vld  = 1'b1;
            n_hold_byte = e_byte;
        end else if (fin) begin
            n_hold_vld = 1'b0;
        end
        if (push) begin
            n_out_vld       = 1'b1;
            n_out_byte      = r_hold_byte;
            n_out_run_last  = fin;
            n_out_text_last = fin && r_eot;
        end else if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= kmpsfr_pkg::S_BUILD;
            r_pos      <= '0;
            r_bi       <= '0;
            r_bk       <= '0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_bi       <= n_bi;
            r_bk       <= n_bk;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_j             <= n_j;
        r_idx           <= n_idx;
        r_end           <= n_end;
        r_nj            <= n_nj;
        r_c             <= n_c;
        r_eot           <= n_eot;
        r_hold_byte     <= n_hold_byte;
        r_out_byte      <= n_out_byte;
        r_out_run_last  <= n_out_run_last;
        r_out_text_last <= n_out_text_last;
    end

    // ports
    assign o_stall     = (r_state != kmpsfr_pkg::S_IDLE);
    assign o_valid     = r_out_vld;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_out_run_last;
    assign o_text_last = r_out_text_last;

    // checks
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kmpsfr_pkg::S_IDLE) |-> !r_hold_vld)
        else $error("hold stage still full while idle");

    a_pos_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == kmpsfr_pkg::S_IDLE) && (plen != '0)) |-> (r_pos < plen))
        else $error("match position not below pattern length");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !pat_wr) |=> (r_state != kmpsfr_pkg::S_IDLE))
        else $error("accepted transaction did not start the sequencer");

    a_text_last_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_text_last) |-> r_out_run_last)
        else $error("text end flagged on a byte that does not end its run");

    a_scan_pos_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kmpsfr_pkg::S_SCAN) |-> (r_j < plen))
        else $error("scan position out of pattern range");

endmodule

`default_nettype wire
